// ----- hw/rtl/channel_gain_with_reduction_defines.svh -----
// assertion macros for the channel gain block
`ifndef CHANNEL_GAIN_WITH_REDUCTION_DEFINES_SVH
`define CHANNEL_GAIN_WITH_REDUCTION_DEFINES_SVH

// clocked check, off while reset is low
`define CGR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds while reset is low
`define CGR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/cgr_pkg.sv -----
package cgr_pkg;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_PROD = 2'd1,
		MODE_SUM  = 2'd2,
		MODE_SSQ  = 2'd3
	} mode_t;

	localparam logic [2:0] CFG_JOIN_MODE = 3'd0;
	localparam logic [2:0] CFG_DIM_COUNT = 3'd1;
	localparam logic [2:0] CFG_GAIN_0    = 3'd2;
	localparam logic [2:0] CFG_GAIN_1    = 3'd3;
	localparam logic [2:0] CFG_GAIN_2    = 3'd4;
	localparam logic [2:0] CFG_GAIN_3    = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int SAMPLE_W    = 16;
	localparam int GAIN_W      = 16;
	localparam int NUM_GAINS   = 4;
	localparam int POS_W       = 2;
	localparam int DIM_W       = 3;
	localparam int SCALED_W    = 24;
	localparam int RESULT_W    = 48;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	localparam logic signed [GAIN_W-1:0]   GAIN_RESET = 16'sd256;
	localparam logic [DIM_W-1:0]           DIM_RESET  = 3'd1;
	localparam logic signed [RESULT_W-1:0] ONE_Q15    = 48'sd32768;

	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef gain_t [NUM_GAINS-1:0] gain_set_t;

	typedef struct packed {
		mode_t                       mode;
		logic [POS_W-1:0]            pos;
		logic                        first;
		logic                        last;
		logic signed [SCALED_W-1:0]  scaled;
	} entry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_MUL  = 2'd1,
		BK_ACC  = 2'd2
	} back_state_t;

endpackage

// ----- hw/rtl/cgr_queue.sv -----
module cgr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cgr_pkg::entry_t     push_data,
	input  logic                pop,
	output cgr_pkg::entry_t     head,
	output cgr_pkg::q_status_t  status
);

	cgr_pkg::entry_t                      mem_q [cgr_pkg::QUEUE_DEPTH];
	logic [cgr_pkg::QUEUE_PTR_W-1:0]      wr_ptr_q;
	logic [cgr_pkg::QUEUE_PTR_W-1:0]      rd_ptr_q;
	logic [cgr_pkg::QUEUE_CNT_W-1:0]      count_q;
	logic                                 do_push;
	logic                                 do_pop;

	assign status.not_empty = (count_q != '0);
	assign status.full      = (count_q == cgr_pkg::QUEUE_CNT_W'(cgr_pkg::QUEUE_DEPTH));
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;
	assign head             = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end else begin
				count_q <= count_q;
			end
		end
	end

endmodule

// ----- hw/rtl/cgr_front.sv -----
module cgr_front #(
	parameter int MaxChannels = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [cgr_pkg::SAMPLE_W-1:0] sample,
	input  cgr_pkg::mode_t                      join_mode,
	input  logic [cgr_pkg::DIM_W-1:0]           dim_count,
	input  cgr_pkg::gain_set_t                  gains,
	input  cgr_pkg::q_status_t                  q_status,
	output logic                                push,
	output cgr_pkg::entry_t                     push_data
);

	logic [cgr_pkg::POS_W-1:0]                      pos_q;
	logic [cgr_pkg::DIM_W-1:0]                      dim_eff;
	logic                                           last;
	logic signed [cgr_pkg::GAIN_W-1:0]              gain;
	logic signed [cgr_pkg::SAMPLE_W+cgr_pkg::GAIN_W-1:0] product;

	// a zero count acts as one, too large a count as the channel limit
	always_comb begin
		priority if (dim_count == '0) begin
			dim_eff = cgr_pkg::DIM_W'(1);
		end else if (dim_count > cgr_pkg::DIM_W'(MaxChannels)) begin
			dim_eff = cgr_pkg::DIM_W'(MaxChannels);
		end else begin
			dim_eff = dim_count;
		end
	end

	assign last    = ({1'b0, pos_q} >= (dim_eff - 1'b1));
	assign gain    = gains[pos_q];
	assign product = sample * gain;

	assign in_stall = q_status.full;
	assign push     = in_valid && !in_stall;

	always_comb begin
		push_data.mode   = join_mode;
		push_data.pos    = pos_q;
		push_data.first  = (pos_q == '0);
		push_data.last   = last;
		// floor shift by eight
		push_data.scaled = product[cgr_pkg::SAMPLE_W+cgr_pkg::GAIN_W-1:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= last ? '0 : pos_q + 1'b1;
		end
	end

endmodule

// ----- hw/rtl/cgr_back.sv -----
module cgr_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cgr_pkg::entry_t                      head,
	input  cgr_pkg::q_status_t                   q_status,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [cgr_pkg::RESULT_W-1:0]  result_value,
	output logic [cgr_pkg::POS_W-1:0]            channel_index,
	output logic                                 saturated
);

	localparam int HiW   = cgr_pkg::RESULT_W - 15;
	localparam int LoW   = 16;
	localparam int PhW   = HiW + cgr_pkg::SCALED_W;
	localparam int PlW   = LoW + cgr_pkg::SCALED_W;
	localparam int WideW = PhW + 1;

	cgr_pkg::back_state_t                    state_q;
	cgr_pkg::back_state_t                    state_d;
	cgr_pkg::entry_t                         ent_q;
	logic signed [cgr_pkg::RESULT_W-1:0]     base_q;
	logic                                    clipb_q;
	logic signed [PhW-1:0]                   prod_hi_q;
	logic signed [PlW-1:0]                   prod_lo_q;
	logic signed [cgr_pkg::RESULT_W-1:0]     acc_q;
	logic                                    clip_q;
	logic                                    out_valid_q;
	logic signed [cgr_pkg::RESULT_W-1:0]     result_q;
	logic [cgr_pkg::POS_W-1:0]               index_q;
	logic                                    sat_q;

	logic signed [cgr_pkg::RESULT_W-1:0]     base;
	logic                                    clipb;
	logic signed [HiW-1:0]                   mul_a;
	logic signed [LoW-1:0]                   lo_part;
	logic signed [WideW-1:0]                 sum_w;
	logic                                    ovf;
	logic signed [cgr_pkg::RESULT_W-1:0]     acc_new;
	logic                                    clip_new;
	logic                                    emit;
	logic                                    out_free;
	logic                                    commit;

	assign out_valid     = out_valid_q;
	assign result_value  = result_q;
	assign channel_index = index_q;
	assign saturated     = sat_q;

	assign emit     = (ent_q.mode == cgr_pkg::MODE_OFF) || ent_q.last;
	assign out_free = !out_valid_q || !out_stall;

	// frame start reloads the accumulator and clears the clip flag
	always_comb begin
		priority if (ent_q.first) begin
			base  = (ent_q.mode == cgr_pkg::MODE_PROD) ? cgr_pkg::ONE_Q15 : '0;
			clipb = 1'b0;
		end else begin
			base  = acc_q;
			clipb = clip_q;
		end
	end

	assign lo_part = {1'b0, base[14:0]};

	always_comb begin
		if (ent_q.mode == cgr_pkg::MODE_SSQ) begin
			mul_a = {{(HiW-cgr_pkg::SCALED_W){ent_q.scaled[cgr_pkg::SCALED_W-1]}},
				ent_q.scaled};
		end else begin
			mul_a = base[cgr_pkg::RESULT_W-1:15];
		end
	end

	always_comb begin
		unique case (ent_q.mode)
			cgr_pkg::MODE_PROD: begin
				sum_w = {prod_hi_q[PhW-1], prod_hi_q}
					+ {{(WideW-(PlW-15)){prod_lo_q[PlW-1]}}, prod_lo_q[PlW-1:15]};
			end
			cgr_pkg::MODE_SUM: begin
				sum_w = {{(WideW-cgr_pkg::RESULT_W){base_q[cgr_pkg::RESULT_W-1]}}, base_q}
					+ {{(WideW-cgr_pkg::SCALED_W){ent_q.scaled[cgr_pkg::SCALED_W-1]}},
						ent_q.scaled};
			end
			cgr_pkg::MODE_SSQ: begin
				sum_w = {{(WideW-cgr_pkg::RESULT_W){base_q[cgr_pkg::RESULT_W-1]}}, base_q}
					+ {{(WideW-(PhW-15)){prod_hi_q[PhW-1]}}, prod_hi_q[PhW-1:15]};
			end
			default: begin
				sum_w = '0;
			end
		endcase
	end

	// saturate to 48 bits
	assign ovf = !((&sum_w[WideW-1:cgr_pkg::RESULT_W-1]) || !(|sum_w[WideW-1:cgr_pkg::RESULT_W-1]));

	always_comb begin
		priority if (!ovf) begin
			acc_new = sum_w[cgr_pkg::RESULT_W-1:0];
		end else if (sum_w[WideW-1]) begin
			acc_new = {1'b1, {(cgr_pkg::RESULT_W-1){1'b0}}};
		end else begin
			acc_new = {1'b0, {(cgr_pkg::RESULT_W-1){1'b1}}};
		end
	end

	assign clip_new = clipb_q || ovf;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cgr_pkg::BK_IDLE: begin
				if (q_status.not_empty) begin
					state_d = cgr_pkg::BK_MUL;
				end
			end
			cgr_pkg::BK_MUL: begin
				state_d = cgr_pkg::BK_ACC;
			end
			cgr_pkg::BK_ACC: begin
				if (!emit || out_free) begin
					state_d = cgr_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = cgr_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		commit = 1'b0;
		unique case (state_q)
			cgr_pkg::BK_IDLE: begin
				pop = q_status.not_empty;
			end
			cgr_pkg::BK_MUL: begin
			end
			cgr_pkg::BK_ACC: begin
				commit = !emit || out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
		end
		if (state_q == cgr_pkg::BK_MUL) begin
			base_q    <= base;
			clipb_q   <= clipb;
			prod_hi_q <= PhW'(mul_a * ent_q.scaled);
			prod_lo_q <= PlW'(lo_part * ent_q.scaled);
		end
		if (commit && emit) begin
			if (ent_q.mode == cgr_pkg::MODE_OFF) begin
				result_q <= {{(cgr_pkg::RESULT_W-cgr_pkg::SCALED_W){ent_q.scaled[cgr_pkg::SCALED_W-1]}},
					ent_q.scaled};
				index_q  <= ent_q.pos;
				sat_q    <= 1'b0;
			end else begin
				result_q <= acc_new;
				index_q  <= '0;
				sat_q    <= clip_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cgr_pkg::BK_IDLE;
			acc_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit && (ent_q.mode != cgr_pkg::MODE_OFF)) begin
				acc_q  <= acc_new;
				clip_q <= clip_new;
			end
			priority if (commit && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end else begin
				out_valid_q <= out_valid_q;
			end
		end
	end

endmodule

// ----- hw/rtl/channel_gain_with_reduction.sv -----
// Channel gain with frame reduction. Each 16-bit Q1.15 word is scaled by the Q8.8 gain of
// its channel in the frame; in off mode every scaled word comes out with its channel, in
// the product, sum and sum-of-squares modes one 48-bit saturated result comes out at the
// last channel of each frame, with saturated set when any step of the frame clipped. The
// front takes a word in any cycle in which its two-entry queue has room; the back end
// takes each word in turn through its fetch, multiply and accumulate steps, and fetches
// the next word only once the last one is through. A result is registered in turn in the
// fetched entry, the products and the result register. The user must write the registers
// only while no word is in flight; the block itself does not enforce this.
module channel_gain_with_reduction #(
	parameter int MAX_CHANNELS = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [cgr_pkg::SAMPLE_W-1:0]    sample,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [cgr_pkg::RESULT_W-1:0]    result_value,
	output logic [cgr_pkg::POS_W-1:0]              channel_index,
	output logic                                   saturated,
	input  logic                                   cfg_we,
	input  logic [cgr_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [cgr_pkg::CFG_DATA_W-1:0]         cfg_data
);

	cgr_pkg::mode_t              join_mode_q;
	logic [cgr_pkg::DIM_W-1:0]   dim_count_q;
	cgr_pkg::gain_set_t          gains_q;
	cgr_pkg::q_status_t          q_status;
	cgr_pkg::entry_t             push_data;
	cgr_pkg::entry_t             head;
	logic                        push;
	logic                        pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			join_mode_q <= cgr_pkg::MODE_OFF;
			dim_count_q <= cgr_pkg::DIM_RESET;
			gains_q     <= {cgr_pkg::NUM_GAINS{cgr_pkg::GAIN_RESET}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				cgr_pkg::CFG_JOIN_MODE: join_mode_q <= cgr_pkg::mode_t'(cfg_data[1:0]);
				cgr_pkg::CFG_DIM_COUNT: dim_count_q <= cfg_data[cgr_pkg::DIM_W-1:0];
				cgr_pkg::CFG_GAIN_0:    gains_q[0]  <= cfg_data;
				cgr_pkg::CFG_GAIN_1:    gains_q[1]  <= cfg_data;
				cgr_pkg::CFG_GAIN_2:    gains_q[2]  <= cfg_data;
				cgr_pkg::CFG_GAIN_3:    gains_q[3]  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cgr_front #(
		.MaxChannels(MAX_CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.join_mode (join_mode_q),
		.dim_count (dim_count_q),
		.gains     (gains_q),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	cgr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	cgr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_value  (result_value),
		.channel_index (channel_index),
		.saturated     (saturated)
	);

endmodule

// ----- hw/rtl/cgr_checker.sv -----
`include "channel_gain_with_reduction_defines.svh"

module cgr_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [cgr_pkg::RESULT_W-1:0]   result_value,
	input logic [cgr_pkg::POS_W-1:0]             channel_index,
	input logic                                  saturated
);

	// a held word stays offered
	`CGR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result word dropped while stalled")

	// a held word keeps its payload
	`CGR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(result_value) && $stable(channel_index) && $stable(saturated), "result word changed while stalled")

	// per-channel words never carry the clip flag, frame results always carry channel zero
	`CGR_ASSERT(a_sat_idx, out_valid && saturated |-> channel_index == '0, "clip flag on a per-channel word")

	// nothing offered in the cycle after reset is seen
	`CGR_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !out_valid, "result word offered after reset")

endmodule

bind channel_gain_with_reduction cgr_checker u_cgr_checker (.*);
